### src/cpr_pkg.sv
// Shared types and constants for the clock page replacer.
package cpr_pkg;

	localparam int MODE_W  = 2;
	localparam int FRAME_W = 6;
	localparam int SLOTS_W = 7;
	localparam int COUNT_W = 7;

	localparam logic [MODE_W-1:0]  MODE_VICTIM = 2'd0;
	localparam logic [MODE_W-1:0]  MODE_PIN    = 2'd1;
	localparam logic [MODE_W-1:0]  MODE_UNPIN  = 2'd2;

	localparam logic [SLOTS_W-1:0] SLOTS_RESET = 7'd64;
	localparam logic [COUNT_W-1:0] COUNT_MAX   = 7'd127;

	typedef enum logic [1:0] {
		FS_ABSENT = 2'd0,
		FS_UNREF  = 2'd1,
		FS_REF    = 2'd2,
		FS_PINNED = 2'd3
	} fs_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_START,
		S_V_RING,
		S_V_STAT,
		S_P_STAT,
		S_U_RING,
		S_RESP
	} cpr_state_t;

	typedef struct packed {
		logic clear_wr;
		logic accept;
		logic stat_rd_item;
		logic advance;
		logic ref_clear;
		logic evict;
		logic pin;
		logic mark_ref;
		logic place;
		logic load_rsp;
	} cpr_cmd_t;

	typedef struct packed {
		logic              clear_last;
		logic [MODE_W-1:0] mode;
		logic              frame_ok;
		logic              ring_valid;
		fs_t               stat;
		logic              step_last_victim;
		logic              step_last_unpin;
	} cpr_sts_t;

endpackage

### src/cpr_if.sv
// Handshake channels of the clock page replacer: request, result and register write.
interface cpr_req_if import cpr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [MODE_W-1:0]  mode;
	logic [FRAME_W-1:0] frame_number;

	modport source (output valid, mode, frame_number, input ready);
	modport sink (input valid, mode, frame_number, output ready);
endinterface

interface cpr_rsp_if import cpr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               ok;
	logic [FRAME_W-1:0] victim_frame;
	logic [COUNT_W-1:0] evictable_count;

	modport source (output valid, ok, victim_frame, evictable_count, input ready);
	modport sink (input valid, ok, victim_frame, evictable_count, output ready);
endinterface

interface cpr_cfg_if import cpr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [SLOTS_W-1:0] slots_in_use;

	modport source (output valid, slots_in_use, input ready);
	modport sink (input valid, slots_in_use, output ready);
endinterface

### src/clock_page_replacer_core.sv
// Top level of the CLOCK page replacer: victim pick, pin and unpin over a slot ring.
// Unused modes and frames out of range go straight to the result; pin and unpin first read
// the frame status. A victim scan reads each slot from the hand, and the status of an occupied
// one, until it evicts an unreferenced frame or has stepped twice over the slots in use; an
// unpin placement steps on to an empty slot, at most once over them. A result waits while the
// last one is still held for the sink. Items go one at a time, the next taken the cycle after
// a result is registered. Reset: a clearing pass empties both memories; no item then.
module clock_page_replacer_core import cpr_pkg::*; #(
	parameter int NUM_FRAMES = 64
) (
	input logic      clk,
	input logic      arst_n,
	cpr_cfg_if.sink  cfg,
	cpr_req_if.sink  req,
	cpr_rsp_if.source rsp
);

	cpr_cmd_t cmd;
	cpr_sts_t sts;

	// register writes are always taken; the user must make them arrive only while the block is idle (not enforced here)
	assign cfg.ready = 1'b1;

	// sequencer: one state per scan phase, holds the result until the sink takes it
	cpr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp.valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	// memories, hand, evictable count and the result register
	cpr_datapath #(
		.NUM_FRAMES (NUM_FRAMES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg.valid),
		.cfg_slots  (cfg.slots_in_use),
		.req_mode   (req.mode),
		.req_frame  (req.frame_number),
		.cmd        (cmd),
		.sts        (sts),
		.rsp_ok     (rsp.ok),
		.rsp_victim (rsp.victim_frame),
		.rsp_count  (rsp.evictable_count)
	);

	// at most one memory update per cycle
	a_one_update: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clear_wr, cmd.ref_clear, cmd.evict, cmd.pin, cmd.mark_ref, cmd.place}))
		else $error("two memory updates in one cycle");

	// an accepted item closes the request side until its result is registered
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while an item is in work");

	// no item enters during the clearing pass
	a_clear_block: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_wr |-> !req.ready)
		else $error("request ready during clearing pass");

	// a victim frame is reported only with success
	a_victim_ok: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.load_rsp) |-> (rsp.ok || rsp.victim_frame == '0))
		else $error("victim frame without success");

endmodule

### src/cpr_ctrl.sv
// Controller state machine of the clock page replacer.
module cpr_ctrl import cpr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  logic     rsp_ready,
	output logic     rsp_valid,
	input  cpr_sts_t sts,
	output cpr_cmd_t cmd
);

	cpr_state_t state_q, state_d;
	logic       rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (sts.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_START;
				end
			end
			S_START: begin
				if (sts.mode == MODE_VICTIM) begin
					state_d = S_V_RING;
				end else if ((sts.mode == MODE_PIN || sts.mode == MODE_UNPIN) && sts.frame_ok) begin
					cmd.stat_rd_item = 1'b1;
					state_d          = S_P_STAT;
				end else begin
					state_d = S_RESP;
				end
			end
			S_V_RING: begin
				if (sts.ring_valid) begin
					state_d = S_V_STAT;
				end else begin
					cmd.advance = 1'b1;
					if (sts.step_last_victim) begin
						state_d = S_RESP;
					end
				end
			end
			S_V_STAT: begin
				if (sts.stat == FS_UNREF) begin
					cmd.evict = 1'b1;
					state_d   = S_RESP;
				end else begin
					cmd.ref_clear = (sts.stat == FS_REF);
					cmd.advance   = 1'b1;
					state_d       = sts.step_last_victim ? S_RESP : S_V_RING;
				end
			end
			S_P_STAT: begin
				if (sts.mode == MODE_PIN) begin
					cmd.pin = (sts.stat != FS_ABSENT);
					state_d = S_RESP;
				end else if (sts.stat != FS_ABSENT) begin
					cmd.mark_ref = 1'b1;
					state_d      = S_RESP;
				end else begin
					state_d = S_U_RING;
				end
			end
			S_U_RING: begin
				if (!sts.ring_valid) begin
					cmd.place = 1'b1;
					state_d   = S_RESP;
				end else begin
					cmd.advance = 1'b1;
					if (sts.step_last_unpin) begin
						state_d = S_RESP;
					end
				end
			end
			S_RESP: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.load_rsp = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

### src/cpr_datapath.sv
// Datapath of the clock page replacer: frame status and slot ring memories, hand, counters.
module cpr_datapath import cpr_pkg::*; #(
	parameter int NUM_FRAMES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic [SLOTS_W-1:0] cfg_slots,
	input  logic [MODE_W-1:0]  req_mode,
	input  logic [FRAME_W-1:0] req_frame,
	input  cpr_cmd_t           cmd,
	output cpr_sts_t           sts,
	output logic               rsp_ok,
	output logic [FRAME_W-1:0] rsp_victim,
	output logic [COUNT_W-1:0] rsp_count
);

	localparam int FW = $clog2(NUM_FRAMES);
	localparam int CW = $clog2(NUM_FRAMES + 1);
	localparam int AW = CW + 1;
	localparam int SW = $clog2(2 * NUM_FRAMES);
	localparam int IW = (CW > FRAME_W) ? CW : FRAME_W;
	localparam int KW = (CW > SLOTS_W) ? CW : SLOTS_W;
	localparam int VW = (FW > FRAME_W) ? FW : FRAME_W;
	localparam int NW = (CW > COUNT_W) ? CW : COUNT_W;

	// slot ring entry: valid bit on top, frame below
	logic [FW:0]        ring_mem [NUM_FRAMES];
	fs_t                stat_mem [NUM_FRAMES];

	logic [SLOTS_W-1:0] slots_q;
	logic [FW-1:0]      hand_q, hand_d;
	logic [CW-1:0]      cap_q, cap_in;
	logic [SW-1:0]      step_q;
	logic [CW-1:0]      cnt_q, cnt_d;
	logic [FW-1:0]      clr_q;
	logic [MODE_W-1:0]  mode_q;
	logic [FW-1:0]      fr_q;
	logic               fr_ok_q;
	logic               res_ok_q;
	logic [FW-1:0]      res_victim_q;
	logic [FW:0]        ring_rd_q;
	fs_t                stat_rd_q;

	logic [KW-1:0]      slots_x;
	logic [IW-1:0]      fr_x;
	logic [CW-1:0]      hand_inc;
	logic [FW-1:0]      hand_adv;
	logic [FW-1:0]      ring_frame;
	logic [FW-1:0]      stat_rd_addr;
	logic               stat_we;
	logic [FW-1:0]      stat_wa;
	fs_t                stat_wd;
	logic               ring_we;
	logic [FW-1:0]      ring_wa;
	logic [FW:0]        ring_wd;
	logic [VW-1:0]      victim_x;
	logic [NW-1:0]      cnt_x;

	// sweep length: zero counts as one, saturate at the frame count
	always_comb begin
		slots_x = KW'(slots_q);
		if (slots_x == '0) begin
			cap_in = CW'(1);
		end else if (slots_x > KW'(NUM_FRAMES)) begin
			cap_in = CW'(NUM_FRAMES);
		end else begin
			cap_in = slots_x[CW-1:0];
		end
	end

	assign fr_x       = IW'(req_frame);
	assign ring_frame = ring_rd_q[FW-1:0];
	assign hand_inc   = CW'(hand_q) + CW'(1);
	assign hand_adv   = (hand_inc >= cap_q) ? '0 : hand_inc[FW-1:0];

	always_comb begin
		hand_d = hand_q;
		if (cmd.accept) begin
			hand_d = (CW'(hand_q) >= cap_in) ? '0 : hand_q;
		end else if (cmd.advance || cmd.place) begin
			hand_d = hand_adv;
		end
	end

	always_comb begin
		cnt_d = cnt_q;
		if (cmd.pin && (stat_rd_q == FS_UNREF || stat_rd_q == FS_REF)) begin
			cnt_d = cnt_q - CW'(1);
		end else if (cmd.mark_ref && stat_rd_q == FS_PINNED) begin
			cnt_d = cnt_q + CW'(1);
		end else if (cmd.evict) begin
			cnt_d = cnt_q - CW'(1);
		end else if (cmd.place) begin
			cnt_d = cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= SLOTS_RESET;
			hand_q  <= '0;
			cnt_q   <= '0;
			clr_q   <= '0;
			rsp_ok  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				slots_q <= cfg_slots;
			end
			hand_q <= hand_d;
			cnt_q  <= cnt_d;
			if (cmd.clear_wr) begin
				clr_q <= clr_q + FW'(1);
			end
			if (cmd.load_rsp) begin
				rsp_ok <= res_ok_q;
			end
		end
	end

	// item fields, scan counter and result
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q       <= req_mode;
			fr_q         <= fr_x[FW-1:0];
			fr_ok_q      <= (fr_x < IW'(NUM_FRAMES));
			cap_q        <= cap_in;
			step_q       <= '0;
			res_ok_q     <= 1'b0;
			res_victim_q <= '0;
		end else begin
			if (cmd.advance) begin
				step_q <= step_q + SW'(1);
			end
			if (cmd.evict) begin
				res_victim_q <= ring_frame;
			end
			if (cmd.evict || cmd.pin || cmd.mark_ref || cmd.place) begin
				res_ok_q <= 1'b1;
			end
		end
	end

	assign victim_x = VW'(res_victim_q);
	assign cnt_x    = NW'(cnt_q);

	always_ff @(posedge clk) begin
		if (cmd.load_rsp) begin
			rsp_victim <= victim_x[FRAME_W-1:0];
			rsp_count  <= (cnt_x > NW'(COUNT_MAX)) ? COUNT_MAX : cnt_x[COUNT_W-1:0];
		end
	end

	// status memory write port
	always_comb begin
		stat_we = 1'b1;
		stat_wa = fr_q;
		stat_wd = FS_ABSENT;
		if (cmd.clear_wr) begin
			stat_wa = clr_q;
		end else if (cmd.ref_clear) begin
			stat_wa = ring_frame;
			stat_wd = FS_UNREF;
		end else if (cmd.evict) begin
			stat_wa = ring_frame;
		end else if (cmd.pin) begin
			stat_wd = FS_PINNED;
		end else if (cmd.mark_ref || cmd.place) begin
			stat_wd = FS_REF;
		end else begin
			stat_we = 1'b0;
		end
	end

	// ring memory write port
	always_comb begin
		ring_we = 1'b1;
		ring_wa = hand_q;
		ring_wd = '0;
		if (cmd.clear_wr) begin
			ring_wa = clr_q;
		end else if (cmd.place) begin
			ring_wd = {1'b1, fr_q};
		end else if (!cmd.evict) begin
			ring_we = 1'b0;
		end
	end

	assign stat_rd_addr = cmd.stat_rd_item ? fr_q : ring_frame;

	always_ff @(posedge clk) begin
		if (stat_we) begin
			stat_mem[stat_wa] <= stat_wd;
		end
		stat_rd_q <= stat_mem[stat_rd_addr];
	end

	// read ahead at the hand's next position so the data lines up with hand_q
	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[ring_wa] <= ring_wd;
		end
		ring_rd_q <= ring_mem[hand_d];
	end

	always_comb begin
		sts                  = '0;
		sts.clear_last       = (clr_q == FW'(NUM_FRAMES - 1));
		sts.mode             = mode_q;
		sts.frame_ok         = fr_ok_q;
		sts.ring_valid       = ring_rd_q[FW];
		sts.stat             = stat_rd_q;
		sts.step_last_victim = (AW'(step_q) == AW'({cap_q, 1'b0}) - AW'(1));
		sts.step_last_unpin  = (AW'(step_q) == AW'(cap_q) - AW'(1));
	end

endmodule
